FILE: sv/double_tap_gesture_detector_assert.svh
// Assertion macros used by the double-tap detector checker.
`ifndef DOUBLE_TAP_GESTURE_DETECTOR_ASSERT_SVH
`define DOUBLE_TAP_GESTURE_DETECTOR_ASSERT_SVH

// Clocked implication check, disabled while reset is asserted.
`define DTGD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("double tap detector assertion failed");

// Condition that must never be true.
`define DTGD_NEVER(lbl, clk, rst_n, cond) \
	`DTGD_ASSERT(lbl, clk, rst_n, !(cond))

`endif

FILE: sv/dtgd_pkg.sv
// Types and constants of the double-tap gesture detector.
package dtgd_pkg;

	localparam int WINDOW_W   = 24;
	localparam int RADIUS_W   = 12;
	localparam int RADIUS_SQ_W = 2 * RADIUS_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int REV_W      = 32;
	localparam int DETAIL_W   = 8;
	localparam int IDENT_W    = 32;
	localparam int ROT_W      = 2;
	localparam int ACTION_W   = 8;

	localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = WINDOW_W'(300000);
	localparam logic [RADIUS_SQ_W-1:0] RADIUS_SQ_RESET = RADIUS_SQ_W'(40 * 40);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CMD_PRESS  = 2'd0,
		CMD_TAP    = 2'd1,
		CMD_POLL   = 2'd2,
		CMD_CANCEL = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [WINDOW_W-1:0]    window_us;
		logic [RADIUS_SQ_W-1:0] radius_sq;
	} cfg_regs_t;

	typedef struct packed {
		logic                dismissed;
		logic                fired;
		logic [ACTION_W-1:0] fired_action;
	} res_t;

endpackage

FILE: sv/dtgd_if.sv
// Channel interfaces: touch events, results and configuration writes.
interface dtgd_evt_if #(
	parameter int COORD_BITS = 12,
	parameter int TIME_BITS  = 48
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            cmd;
	logic [TIME_BITS-1:0]  now_us;
	logic [COORD_BITS-1:0] tap_x;
	logic [COORD_BITS-1:0] tap_y;
	logic                  item_active;
	logic [31:0]           item_revision;
	logic [7:0]            item_detail;
	logic [31:0]           item_ident;
	logic [1:0]            screen_rotation;
	logic [7:0]            action_code;

	modport source (
		output valid, cmd, now_us, tap_x, tap_y, item_active, item_revision,
			item_detail, item_ident, screen_rotation, action_code,
		input ready
	);
	modport sink (
		input valid, cmd, now_us, tap_x, tap_y, item_active, item_revision,
			item_detail, item_ident, screen_rotation, action_code,
		output ready
	);
endinterface

interface dtgd_res_if;
	logic       valid;
	logic       ready;
	logic       dismissed;
	logic       fired;
	logic [7:0] fired_action;

	modport source (output valid, dismissed, fired, fired_action, input ready);
	modport sink (input valid, dismissed, fired, fired_action, output ready);
endinterface

interface dtgd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  idx;
	logic [23:0] wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

FILE: sv/dtgd_cfg.sv
// Configuration registers: tap window and squared tap radius.
module dtgd_cfg
	import dtgd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	dtgd_cfg_if.sink        cfg,
	output cfg_regs_t       regs
);

	cfg_regs_t regs_q;
	logic [RADIUS_W-1:0] radius;

	assign cfg.ready = 1'b1;
	assign radius    = cfg.wdata[RADIUS_W-1:0];
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.window_us <= WINDOW_RESET;
			regs_q.radius_sq <= RADIUS_SQ_RESET;
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_WINDOW: regs_q.window_us <= cfg.wdata[WINDOW_W-1:0];
				REG_RADIUS: regs_q.radius_sq <= RADIUS_SQ_W'(radius) * RADIUS_SQ_W'(radius);
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/dtgd_core.sv
// Gesture state and per-event decision logic.
module dtgd_core
	import dtgd_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int TIME_BITS  = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [1:0]            cmd,
	input  logic [TIME_BITS-1:0]  now_us,
	input  logic [COORD_BITS-1:0] tap_x,
	input  logic [COORD_BITS-1:0] tap_y,
	input  logic                  item_active,
	input  logic [REV_W-1:0]      item_revision,
	input  logic [DETAIL_W-1:0]   item_detail,
	input  logic [IDENT_W-1:0]    item_ident,
	input  logic [ROT_W-1:0]      screen_rotation,
	input  logic [ACTION_W-1:0]   action_code,
	input  cfg_regs_t             regs,
	output res_t                  result
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int CMP_W = (SQ_W + 1 > RADIUS_SQ_W) ? SQ_W + 1 : RADIUS_SQ_W;

	logic                  pending_q, pressed_q, second_q;
	logic [REV_W-1:0]      saved_revision_q;
	logic [DETAIL_W-1:0]   saved_detail_q;
	logic [ROT_W-1:0]      saved_rotation_q;
	logic [COORD_BITS-1:0] saved_x_q, saved_y_q;
	logic [TIME_BITS-1:0]  start_time_q;
	logic [IDENT_W-1:0]    saved_ident_q;
	logic [ACTION_W-1:0]   saved_action_q;

	logic                  pending_nxt, pressed_nxt, second_nxt, load;
	logic [TIME_BITS-1:0]  elapsed, window;
	logic                  item_match, in_radius, dis;
	logic [COORD_BITS-1:0] dx, dy;
	logic [SQ_W-1:0]       dx2, dy2;
	logic [CMP_W-1:0]      dist2;

	assign elapsed    = now_us - start_time_q;
	assign window     = TIME_BITS'(regs.window_us);
	assign item_match = item_active && saved_revision_q == item_revision &&
		saved_detail_q == item_detail && saved_ident_q == item_ident &&
		saved_rotation_q == screen_rotation;

	assign dx        = (tap_x >= saved_x_q) ? tap_x - saved_x_q : saved_x_q - tap_x;
	assign dy        = (tap_y >= saved_y_q) ? tap_y - saved_y_q : saved_y_q - tap_y;
	assign dx2       = SQ_W'(dx) * SQ_W'(dx);
	assign dy2       = SQ_W'(dy) * SQ_W'(dy);
	assign dist2     = CMP_W'(dx2) + CMP_W'(dy2);
	assign in_radius = dist2 <= CMP_W'(regs.radius_sq);
	assign dis       = pending_q && item_match && second_q && in_radius;

	always_comb begin
		pending_nxt = pending_q;
		pressed_nxt = pressed_q;
		second_nxt  = second_q;
		load        = 1'b0;
		result      = '0;
		case (cmd_t'(cmd))
			CMD_PRESS: begin
				pressed_nxt = 1'b1;
				second_nxt  = pending_q && elapsed <= window;
			end
			CMD_TAP: begin
				pending_nxt = 1'b0;
				pressed_nxt = 1'b0;
				second_nxt  = 1'b0;
				if (dis) begin
					result.dismissed = 1'b1;
				end else if (item_active) begin
					pending_nxt = 1'b1;
					load        = 1'b1;
				end
			end
			CMD_POLL: begin
				if (pending_q) begin
					if (!item_match) begin
						pending_nxt = 1'b0;
						pressed_nxt = 1'b0;
						second_nxt  = 1'b0;
					end else if (!pressed_q && elapsed >= window) begin
						pending_nxt = 1'b0;
						if (saved_action_q != '0) begin
							result.fired        = 1'b1;
							result.fired_action = saved_action_q;
						end
					end
				end
			end
			CMD_CANCEL: begin
				pending_nxt = 1'b0;
				pressed_nxt = 1'b0;
				second_nxt  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			pressed_q <= 1'b0;
			second_q  <= 1'b0;
		end else if (step) begin
			pending_q <= pending_nxt;
			pressed_q <= pressed_nxt;
			second_q  <= second_nxt;
		end
	end

	// saved fields only matter while a gesture is pending
	always_ff @(posedge clk) begin
		if (step && load) begin
			saved_revision_q <= item_revision;
			saved_detail_q   <= item_detail;
			saved_ident_q    <= item_ident;
			saved_rotation_q <= screen_rotation;
			saved_x_q        <= tap_x;
			saved_y_q        <= tap_y;
			start_time_q     <= now_us;
			saved_action_q   <= action_code;
		end
	end

endmodule

FILE: sv/double_tap_gesture_detector.sv
// Top level of the double-tap gesture detector.
//
//   channel  dir  handshake      beat
//   evt      in   valid/ready    one touch event (press, tap, poll, cancel)
//   res      out  valid/ready    one result per event
//   cfg      in   valid/ready    register write, ready held high
//
// One event per cycle while res.ready is high; the result is registered.
// Event register feeds the decision logic, which updates gesture state and the
// result register in the same cycle. A stalled result holds the event register;
// ready drops only when both are full and res.ready is low.
// Reset clears all flags and restores the default window and radius.
module double_tap_gesture_detector
	import dtgd_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int TIME_BITS  = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	dtgd_evt_if.sink    evt,
	dtgd_res_if.source  res,
	dtgd_cfg_if.sink    cfg
);

	cfg_regs_t regs;
	res_t      result;

	logic                  valid_s1;
	logic [1:0]            cmd_s1;
	logic [TIME_BITS-1:0]  now_us_s1;
	logic [COORD_BITS-1:0] tap_x_s1, tap_y_s1;
	logic                  item_active_s1;
	logic [REV_W-1:0]      item_revision_s1;
	logic [DETAIL_W-1:0]   item_detail_s1;
	logic [IDENT_W-1:0]    item_ident_s1;
	logic [ROT_W-1:0]      screen_rotation_s1;
	logic [ACTION_W-1:0]   action_code_s1;

	logic res_valid_q;
	res_t res_q;
	logic advance, step, take;

	assign advance   = !res_valid_q || res.ready;
	assign step      = valid_s1 && advance;
	assign evt.ready = !valid_s1 || advance;
	assign take      = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (evt.ready) valid_s1 <= evt.valid;
			if (advance) res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1             <= evt.cmd;
			now_us_s1          <= evt.now_us;
			tap_x_s1           <= evt.tap_x;
			tap_y_s1           <= evt.tap_y;
			item_active_s1     <= evt.item_active;
			item_revision_s1   <= evt.item_revision;
			item_detail_s1     <= evt.item_detail;
			item_ident_s1      <= evt.item_ident;
			screen_rotation_s1 <= evt.screen_rotation;
			action_code_s1     <= evt.action_code;
		end
		if (step) res_q <= result;
	end

	dtgd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dtgd_core #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.cmd             (cmd_s1),
		.now_us          (now_us_s1),
		.tap_x           (tap_x_s1),
		.tap_y           (tap_y_s1),
		.item_active     (item_active_s1),
		.item_revision   (item_revision_s1),
		.item_detail     (item_detail_s1),
		.item_ident      (item_ident_s1),
		.screen_rotation (screen_rotation_s1),
		.action_code     (action_code_s1),
		.regs            (regs),
		.result          (result)
	);

	assign res.valid        = res_valid_q;
	assign res.dismissed    = res_q.dismissed;
	assign res.fired        = res_q.fired;
	assign res.fired_action = res_q.fired_action;

endmodule

FILE: sv/dtgd_checker.sv
// Port-level checker for the double-tap gesture detector, bound to the top level.
`include "double_tap_gesture_detector_assert.svh"

module dtgd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       dismissed,
	input logic       fired,
	input logic [7:0] fired_action
);

	`DTGD_NEVER(a_one_outcome, clk, arst_n, res_valid && dismissed && fired)
	`DTGD_ASSERT(a_action_only_when_fired, clk, arst_n, res_valid |-> (fired || fired_action == 8'd0))
	`DTGD_ASSERT(a_ready_when_empty, clk, arst_n, !res_valid |-> evt_ready)
	`DTGD_ASSERT(a_result_from_beat, clk, arst_n, $rose(res_valid) |-> $past(evt_valid && evt_ready, 2))
	`DTGD_ASSERT(a_stall_holds, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(dismissed) && $stable(fired) && $stable(fired_action)))

endmodule

bind double_tap_gesture_detector dtgd_checker u_dtgd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.dismissed    (res.dismissed),
	.fired        (res.fired),
	.fired_action (res.fired_action)
);

FILE: tb/tb_double_tap_gesture_detector.sv
// Self-checking testbench of the double-tap gesture detector: directed and random touch beats.
module tb_double_tap_gesture_detector;
	import dtgd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_LAST  = CFG_IDX_W'(3);
	localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;
	localparam int PHASES = 8;
	localparam int BEATS_PER_PHASE = 172;

	typedef struct packed {
		cmd_t                cmd;
		logic [47:0]         now;
		logic [11:0]         x;
		logic [11:0]         y;
		logic                active;
		logic [REV_W-1:0]    rev;
		logic [DETAIL_W-1:0] detail;
		logic [IDENT_W-1:0]  ident;
		logic [ROT_W-1:0]    rot;
		logic [ACTION_W-1:0] action;
	} touch_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic            ev_valid = 1'b0;
	touch_t          ev_beat = '0;
	logic            res_ready = 1'b0;
	logic            cfg_valid = 1'b0;
	logic [1:0]      cfg_idx = '0;
	logic [23:0]     cfg_wdata = '0;

	touch_t touch_q[$];
	res_t   outcome_q[$];
	int     fail_cnt = 0;
	int     send_idle = 0;
	int     recv_stall = 0;
	int     queued = 0;
	logic [47:0] t_now = '0;

	// predictor state and registers
	logic [WINDOW_W-1:0] win_us = 24'd300000;
	logic [RADIUS_W-1:0] radius = 12'd40;
	logic                g_pending = 1'b0;
	logic                g_pressed = 1'b0;
	logic                g_second = 1'b0;
	logic [REV_W-1:0]    g_rev = '0;
	logic [DETAIL_W-1:0] g_detail = '0;
	logic [ROT_W-1:0]    g_rot = '0;
	logic [11:0]         g_x = '0;
	logic [11:0]         g_y = '0;
	logic [47:0]         g_start = '0;
	logic [IDENT_W-1:0]  g_ident = '0;
	logic [ACTION_W-1:0] g_action = '0;

	dtgd_evt_if #(.COORD_BITS(12), .TIME_BITS(48)) evt_ch();
	dtgd_res_if res_ch();
	dtgd_cfg_if cfg_ch();

	assign evt_ch.valid           = ev_valid;
	assign evt_ch.cmd             = ev_beat.cmd;
	assign evt_ch.now_us          = ev_beat.now;
	assign evt_ch.tap_x           = ev_beat.x;
	assign evt_ch.tap_y           = ev_beat.y;
	assign evt_ch.item_active     = ev_beat.active;
	assign evt_ch.item_revision   = ev_beat.rev;
	assign evt_ch.item_detail     = ev_beat.detail;
	assign evt_ch.item_ident      = ev_beat.ident;
	assign evt_ch.screen_rotation = ev_beat.rot;
	assign evt_ch.action_code     = ev_beat.action;
	assign res_ch.ready           = res_ready;
	assign cfg_ch.valid           = cfg_valid;
	assign cfg_ch.idx             = cfg_idx;
	assign cfg_ch.wdata           = cfg_wdata;

	double_tap_gesture_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void drop_gesture();
		g_pending = 1'b0;
		g_pressed = 1'b0;
		g_second  = 1'b0;
		g_rev     = '0;
		g_detail  = '0;
		g_rot     = '0;
		g_x       = '0;
		g_y       = '0;
		g_start   = '0;
		g_ident   = '0;
		g_action  = '0;
	endfunction

	function automatic res_t predict_outcome(touch_t e);
		res_t        r;
		logic [47:0] age;
		logic [31:0] dx, dy, r2;
		logic        same, hit;
		r = '0;
		age = e.now - g_start;
		same = e.active && g_rev == e.rev && g_detail == e.detail &&
			g_ident == e.ident && g_rot == e.rot;
		case (e.cmd)
			CMD_PRESS: begin
				g_pressed = 1'b1;
				g_second = g_pending && age <= win_us;
			end
			CMD_TAP: begin
				dx = (e.x >= g_x) ? e.x - g_x : g_x - e.x;
				dy = (e.y >= g_y) ? e.y - g_y : g_y - e.y;
				r2 = radius * radius;
				hit = g_pending && same && g_second && dx * dx + dy * dy <= r2;
				drop_gesture();
				if (hit) begin
					r.dismissed = 1'b1;
				end else if (e.active) begin
					g_pending = 1'b1;
					g_rev     = e.rev;
					g_detail  = e.detail;
					g_ident   = e.ident;
					g_rot     = e.rot;
					g_x       = e.x;
					g_y       = e.y;
					g_start   = e.now;
					g_action  = e.action;
				end
			end
			CMD_POLL: begin
				if (g_pending) begin
					if (!same) begin
						drop_gesture();
					end else if (!g_pressed && age >= win_us) begin
						g_pending = 1'b0;
						if (g_action != '0) begin
							r.fired = 1'b1;
							r.fired_action = g_action;
						end
					end
				end
			end
			default: drop_gesture();
		endcase
		return r;
	endfunction

	// driver: predicts on accept, then offers the next beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (ev_valid && evt_ch.ready)
				outcome_q.push_back(predict_outcome(ev_beat));
			if (!ev_valid || evt_ch.ready) begin
				if (touch_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					ev_beat  <= touch_q.pop_front();
					ev_valid <= 1'b1;
				end else begin
					ev_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result beat with no outcome pending");
					fail_cnt++;
				end else begin
					want = outcome_q.pop_front();
					if (res_ch.dismissed !== want.dismissed) begin
						$error("dismissed: expected %0d, got %0d", want.dismissed,
							res_ch.dismissed);
						fail_cnt++;
					end
					if (res_ch.fired !== want.fired) begin
						$error("fired: expected %0d, got %0d", want.fired, res_ch.fired);
						fail_cnt++;
					end
					if (res_ch.fired_action !== want.fired_action) begin
						$error("fired_action: expected %0d, got %0d", want.fired_action,
							res_ch.fired_action);
						fail_cnt++;
					end
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic touch_t mk(cmd_t c, logic [47:0] t, logic [11:0] x, logic [11:0] y,
		logic a, logic [31:0] rev, logic [7:0] det, logic [31:0] id, logic [1:0] rot,
		logic [7:0] act);
		touch_t e;
		e = '{cmd: c, now: t, x: x, y: y, active: a, rev: rev, detail: det, ident: id,
			rot: rot, action: act};
		return e;
	endfunction

	function automatic touch_t random_touch();
		touch_t e;
		e.cmd    = cmd_t'($urandom_range(3));
		e.now    = 48'({$urandom, $urandom});
		e.x      = 12'($urandom);
		e.y      = 12'($urandom);
		e.active = 1'($urandom);
		e.rev    = $urandom;
		e.detail = 8'($urandom);
		e.ident  = $urandom;
		e.rot    = 2'($urandom);
		e.action = 8'($urandom);
		return e;
	endfunction

	function automatic touch_t perturb(touch_t e);
		case ($urandom_range(4))
			0: e.active = 1'b0;
			1: e.rev = e.rev ^ (32'd1 << $urandom_range(31));
			2: e.detail = e.detail ^ (8'd1 << $urandom_range(7));
			3: e.ident = e.ident ^ (32'd1 << $urandom_range(31));
			default: e.rot = e.rot + 2'd1;
		endcase
		return e;
	endfunction

	function automatic logic [47:0] pick_gap();
		logic [47:0] w;
		w = 48'(win_us);
		case ($urandom_range(9))
			7: return w;
			8: return w + 48'd1;
			9: return w + 48'd1 + 48'($urandom_range(win_us));
			default: return 48'($urandom_range(win_us));
		endcase
	endfunction

	task automatic queue_touch(touch_t e);
		touch_q.push_back(e);
		queued++;
	endtask

	task automatic queue_gesture();
		touch_t item, ev;
		int     kind, r;
		item = random_touch();
		item.cmd = CMD_TAP;
		item.active = 1'b1;
		if ($urandom_range(3) == 0)
			item.action = '0;
		item.now = t_now;
		queue_touch(item);
		kind = $urandom_range(9);
		if (kind <= 4) begin
			if ($urandom_range(4) == 0) begin
				t_now = t_now + pick_gap() / 2;
				ev = item;
				ev.cmd = CMD_POLL;
				ev.now = t_now;
				queue_touch(ev);
			end
			t_now = t_now + pick_gap();
			ev = random_touch();
			ev.cmd = CMD_PRESS;
			ev.now = t_now;
			queue_touch(ev);
			t_now = t_now + 48'($urandom_range(50));
			r = radius;
			ev = item;
			ev.now = t_now;
			ev.action = 8'($urandom);
			ev.x = item.x + 12'($urandom_range(2 * r + 2)) - 12'(r + 1);
			ev.y = item.y + 12'($urandom_range(2 * r + 2)) - 12'(r + 1);
			if ($urandom_range(4) == 0)
				ev = perturb(ev);
			queue_touch(ev);
		end else if (kind <= 7) begin
			repeat ($urandom_range(1, 3)) begin
				t_now = t_now + pick_gap();
				ev = item;
				ev.cmd = CMD_POLL;
				ev.now = t_now;
				ev.x = 12'($urandom);
				ev.y = 12'($urandom);
				ev.action = 8'($urandom);
				if ($urandom_range(9) == 0)
					ev = perturb(ev);
				queue_touch(ev);
			end
		end else if (kind == 8) begin
			t_now = t_now + pick_gap();
			ev = random_touch();
			ev.cmd = CMD_CANCEL;
			ev.now = t_now;
			queue_touch(ev);
		end else begin
			ev = item;
			ev.active = 1'b0;
			ev.now = t_now + 48'd1;
			queue_touch(ev);
		end
		t_now = t_now + 48'($urandom_range(20));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_WINDOW: win_us = data;
			REG_RADIUS: radius = data[RADIUS_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (touch_q.size() != 0 || ev_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_directed();
		logic [31:0] ones;
		ones = '1;
		queue_touch(mk(CMD_POLL, 48'd0, 12'd0, 12'd0, 1'b0, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_PRESS, 48'd0, 12'd0, 12'd0, 1'b1, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_TAP, 48'd1, 12'hFFF, 12'hFFF, 1'b0, ones, 8'hFF, ones, 2'd3,
			8'hFF));
		// gesture straddling the time wrap, dismissed at exactly the radius
		queue_touch(mk(CMD_TAP, TIME_TOP - 48'd9, 12'hFFF, 12'hFFF, 1'b1, ones, 8'hFF,
			ones, 2'd3, 8'hFF));
		queue_touch(mk(CMD_PRESS, 48'd5, 12'd0, 12'd0, 1'b0, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_TAP, 48'd6, 12'hFFF - 12'd24, 12'hFFF - 12'd32, 1'b1, ones,
			8'hFF, ones, 2'd3, 8'h11));
		// press right at the window edge, tap just outside the radius
		queue_touch(mk(CMD_TAP, 48'd1000, 12'd0, 12'd0, 1'b1, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_PRESS, 48'd301000, 12'd0, 12'd0, 1'b1, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_TAP, 48'd301001, 12'd25, 12'd32, 1'b1, '0, '0, '0, 2'd0,
			8'h80));
		queue_touch(mk(CMD_POLL, 48'd601000, 12'd0, 12'd0, 1'b1, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_POLL, 48'd601001, 12'd0, 12'd0, 1'b1, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_POLL, 48'd601002, 12'd0, 12'd0, 1'b1, '0, '0, '0, 2'd0, '0));
		// expiry with no action
		queue_touch(mk(CMD_TAP, 48'd700000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd0));
		queue_touch(mk(CMD_POLL, 48'd1100000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd0));
		// late press blocks firing and does not arm
		queue_touch(mk(CMD_TAP, 48'd2000000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd5));
		queue_touch(mk(CMD_PRESS, 48'd2300001, 12'd0, 12'd0, 1'b0, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_POLL, 48'd2700000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd0));
		queue_touch(mk(CMD_TAP, 48'd2700010, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd5));
		// rotation change cancels on poll
		queue_touch(mk(CMD_POLL, 48'd2700020, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd2, 8'd0));
		queue_touch(mk(CMD_POLL, 48'd9000000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd0));
		queue_touch(mk(CMD_TAP, 48'd9100000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd9));
		queue_touch(mk(CMD_CANCEL, 48'd9100001, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd9));
		queue_touch(mk(CMD_POLL, 48'd9900000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd0));
		// detail differs on the second tap
		queue_touch(mk(CMD_TAP, 48'd10000000, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5A,
			32'hCAFE, 2'd1, 8'd3));
		queue_touch(mk(CMD_PRESS, 48'd10000100, 12'd0, 12'd0, 1'b0, '0, '0, '0, 2'd0, '0));
		queue_touch(mk(CMD_TAP, 48'd10000200, 12'd7, 12'd9, 1'b1, 32'h1234, 8'h5B,
			32'hCAFE, 2'd1, 8'd3));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				1: begin
					write_reg(REG_WINDOW, 24'd0);
					write_reg(REG_RADIUS, 24'd0);
					write_reg(REG_SPARE, 24'($urandom));
				end
				2: begin
					write_reg(REG_WINDOW, 24'hFFFFFF);
					write_reg(REG_RADIUS, {12'($urandom), 12'hFFF});
				end
				3: begin
					write_reg(REG_WINDOW, 24'($urandom_range(1, 2000)));
					write_reg(REG_RADIUS, 24'd40);
					write_reg(REG_LAST, 24'($urandom));
				end
				default: begin
					write_reg(REG_WINDOW, 24'($urandom_range(5000)));
					write_reg(REG_RADIUS, ($urandom_range(4) == 0) ? 24'hFFF :
						24'($urandom_range(300)));
				end
			endcase
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 52; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 52; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			queued = 0;
			if (ph == 0)
				queue_directed();
			t_now = ($urandom_range(3) == 0) ? TIME_TOP - 48'($urandom_range(2000000)) :
				48'({$urandom, $urandom});
			while (queued < BEATS_PER_PHASE) begin
				if ($urandom_range(99) < 15)
					queue_touch(random_touch());
				else
					queue_gesture();
			end
			wait_idle();
		end
		if (fail_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/dtgd_pkg.sv
sv/dtgd_if.sv
sv/dtgd_cfg.sv
sv/dtgd_core.sv
sv/double_tap_gesture_detector.sv
sv/dtgd_checker.sv
tb/tb_double_tap_gesture_detector.sv
